@@ rtl/lwa_pkg.sv @@
// ----------------------------------------------------------------------------
// lwa_pkg: shared types for the leaky weighted activation block
// Action codes, configuration register indexes and sequencer states.
// ----------------------------------------------------------------------------
package lwa_pkg;

  // Fixed field widths
  localparam int unsigned ACTION_W = 2;
  localparam int unsigned INDEX_W  = 6;
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned CFG_W    = 16;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned ACT_W    = 32;

  typedef enum logic [ACTION_W-1:0] {
    ACT_WR_WEIGHT = 2'd0,
    ACT_WR_INPUT  = 2'd1,
    ACT_COMPUTE   = 2'd2
  } action_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STRENGTH = 1'b0,
    CFG_LEAK     = 1'b1
  } cfg_reg_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MAC,
    S_DRAIN,
    S_SC_LO,
    S_SC_HI,
    S_SC_ADD,
    S_FRESH,
    S_BL_OLD,
    S_BL_NEW,
    S_BL_ADD
  } lwa_state_e;

endpackage

@@ rtl/leaky_weighted_activation.sv @@
// ----------------------------------------------------------------------------
// leaky_weighted_activation: neural-field unit activation
// Weight matrix and input vector stores, one shared multiplier under a small
// sequencer: row dot product, strength scaling and leaky blend per unit.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+-------------------------
//  in      | in        | in_valid_i / in_ready_o    | action, unit/input index,
//          |           |                            | sample_value
//  out     | out       | out_valid_o / out_ready_i  | result_unit, unit_activity
//  cfg     | in        | cfg_we_i (no wait)         | cfg_idx_i, cfg_wdata_i
//
//  A compute runs the single multiply-accumulate per cycle over the weight row,
//  then seven steps of scale and blend on the same multiplier.
//  in_ready_o is high only while the sequencer is idle; a finished result sits
//  in the output register, so the next beat is taken while it waits.
//  Reset clears the previous-activity valid bits at once; no clearing pass.
// ----------------------------------------------------------------------------
module leaky_weighted_activation
  import lwa_pkg::*;
#(
  parameter int unsigned UNITS  = 64,
  parameter int unsigned INPUTS = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  // input channel
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [ACTION_W-1:0]  action_i,
  input  logic [INDEX_W-1:0]   unit_index_i,
  input  logic [INDEX_W-1:0]   input_index_i,
  input  logic [SAMPLE_W-1:0]  sample_value_i,
  // output channel
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [INDEX_W-1:0]   result_unit_o,
  output logic [ACT_W-1:0]     unit_activity_o
);

  localparam int unsigned UA_W  = (UNITS > 1) ? $clog2(UNITS) : 1;
  localparam int unsigned IA_W  = (INPUTS > 1) ? $clog2(INPUTS) : 1;
  localparam int unsigned WA_W  = (UNITS * INPUTS > 1) ? $clog2(UNITS * INPUTS) : 1;
  localparam int unsigned SUM_W = 32 + ((INPUTS > 1) ? $clog2(INPUTS) : 0);
  localparam int unsigned ACC_W = (SUM_W + 16 > 54) ? SUM_W + 16 : 54;
  localparam int unsigned RND_W = ACC_W - 21;
  localparam int unsigned MA_W  = 32;
  localparam int unsigned MB_W  = 17;
  localparam int unsigned PR_W  = MA_W + MB_W;

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  lwa_state_e          state_q, state_d;
  logic [CFG_W-1:0]    strength_q, leak_q;
  logic                rd_vld_q, mul_vld_q, out_vld_q;
  logic [UNITS-1:0]    prev_vld_q;

  logic [UA_W-1:0]     unit_q;
  logic [WA_W-1:0]     base_q;
  logic [IA_W-1:0]     k_q;
  logic [SAMPLE_W-1:0] w_rd_q, x_rd_q;
  logic [PR_W-1:0]     prod_q;
  logic [SUM_W-1:0]    sum_q;
  logic [ACC_W-1:0]    acc_q;
  logic [ACT_W-1:0]    old_q, fresh_q;
  logic [INDEX_W-1:0]  res_unit_q;
  logic [ACT_W-1:0]    res_act_q;

  // Memories
  logic [SAMPLE_W-1:0] w_mem    [UNITS*INPUTS];
  logic [SAMPLE_W-1:0] x_mem    [INPUTS];
  logic [ACT_W-1:0]    prev_mem [UNITS];

  // --------------------------------------------------------------------------
  // Input decode
  // --------------------------------------------------------------------------
  logic            in_fire, unit_ok, pos_ok;
  logic            w_we, x_we, start;
  logic [WA_W-1:0] w_waddr, w_raddr;
  logic [UA_W-1:0] uidx;
  logic            k_last, out_free;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign unit_ok    = int'(unit_index_i) < UNITS;
  assign pos_ok     = int'(input_index_i) < INPUTS;
  assign uidx       = UA_W'(unit_index_i);
  assign w_waddr    = WA_W'(unit_index_i) * WA_W'(INPUTS) + WA_W'(input_index_i);
  assign w_raddr    = base_q + WA_W'(k_q);
  assign k_last     = (k_q == IA_W'(INPUTS - 1));
  assign out_free   = !out_vld_q || out_ready_i;

  always_comb begin
    w_we  = 1'b0;
    x_we  = 1'b0;
    start = 1'b0;
    if (in_fire) begin
      unique case (action_i)
        ACT_WR_WEIGHT: w_we  = unit_ok && pos_ok;
        ACT_WR_INPUT:  x_we  = pos_ok;
        ACT_COMPUTE:   start = unit_ok;
        default:       ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:   if (start) state_d = S_MAC;
      S_MAC:    if (k_last) state_d = S_DRAIN;
      S_DRAIN:  if (!rd_vld_q && !mul_vld_q) state_d = S_SC_LO;
      S_SC_LO:  state_d = S_SC_HI;
      S_SC_HI:  state_d = S_SC_ADD;
      S_SC_ADD: state_d = S_FRESH;
      S_FRESH:  state_d = S_BL_OLD;
      S_BL_OLD: state_d = S_BL_NEW;
      S_BL_NEW: state_d = S_BL_ADD;
      S_BL_ADD: if (out_free) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Shared multiplier and adders
  // --------------------------------------------------------------------------
  logic [MA_W-1:0]  mul_a;
  logic [MB_W-1:0]  mul_b;
  logic [PR_W-1:0]  prod_d;
  logic [ACC_W:0]   rnd_full;
  logic [RND_W-1:0] rnd;
  logic [ACT_W-1:0] fresh_sat;
  logic [ACC_W-1:0] bl_sum;

  always_comb begin
    unique case (state_q)
      S_SC_LO: begin
        mul_a = sum_q[31:0];
        mul_b = MB_W'(strength_q);
      end
      S_SC_HI: begin
        mul_a = MA_W'(sum_q >> 32);
        mul_b = MB_W'(strength_q);
      end
      S_BL_OLD: begin
        mul_a = old_q;
        mul_b = MB_W'(17'h10000 - {1'b0, leak_q});
      end
      S_BL_NEW, S_BL_ADD: begin
        // held through the add step so prod_q stays put on an output stall
        mul_a = fresh_q;
        mul_b = MB_W'(leak_q);
      end
      default: begin
        mul_a = MA_W'(w_rd_q);
        mul_b = MB_W'(x_rd_q);
      end
    endcase
  end

  assign prod_d = PR_W'(mul_a) * PR_W'(mul_b);

  // round half up to Q16.16, saturate
  assign rnd_full  = {1'b0, acc_q} + ((ACC_W + 1)'(1) << 21);
  assign rnd       = rnd_full[ACC_W:22];
  assign fresh_sat = (|rnd[RND_W-1:32]) ? '1 : rnd[31:0];

  assign bl_sum = acc_q + ACC_W'(prod_q) + ACC_W'(32768);

  // --------------------------------------------------------------------------
  // Control registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      strength_q <= CFG_W'(6554);
      leak_q     <= CFG_W'(19661);
      rd_vld_q   <= 1'b0;
      mul_vld_q  <= 1'b0;
      out_vld_q  <= 1'b0;
      prev_vld_q <= '0;
    end else begin
      state_q   <= state_d;
      rd_vld_q  <= (state_q == S_MAC);
      mul_vld_q <= rd_vld_q;
      if (cfg_we_i) begin
        unique case (cfg_reg_e'(cfg_idx_i))
          CFG_STRENGTH: strength_q <= cfg_wdata_i;
          CFG_LEAK:     leak_q     <= cfg_wdata_i;
          default:      ;
        endcase
      end
      if (state_q == S_BL_ADD && out_free) begin
        out_vld_q          <= 1'b1;
        prev_vld_q[unit_q] <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Datapath registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    if (start) begin
      unit_q <= uidx;
      base_q <= WA_W'(unit_index_i) * WA_W'(INPUTS);
      k_q    <= '0;
      sum_q  <= '0;
      old_q  <= prev_vld_q[uidx] ? prev_mem[uidx] : '0;
    end else begin
      if (state_q == S_MAC) begin
        k_q <= k_q + IA_W'(1);
      end
      if (mul_vld_q) begin
        sum_q <= sum_q + SUM_W'(prod_q);
      end
    end
    unique case (state_q)
      S_SC_HI, S_BL_NEW: acc_q <= ACC_W'(prod_q);
      S_SC_ADD:          acc_q <= acc_q + (ACC_W'(prod_q) << 32);
      default:           ;
    endcase
    if (state_q == S_FRESH) begin
      fresh_q <= fresh_sat;
    end
    if (state_q == S_BL_ADD && out_free) begin
      res_unit_q       <= INDEX_W'(unit_q);
      res_act_q        <= bl_sum[47:16];
      prev_mem[unit_q] <= bl_sum[47:16];
    end
  end

  // weight row and input vector stores
  always_ff @(posedge clk_i) begin
    if (w_we) begin
      w_mem[w_waddr] <= sample_value_i;
    end
    w_rd_q <= w_mem[w_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (x_we) begin
      x_mem[IA_W'(input_index_i)] <= sample_value_i;
    end
    x_rd_q <= x_mem[k_q];
  end

  assign out_valid_o     = out_vld_q;
  assign result_unit_o   = res_unit_q;
  assign unit_activity_o = res_act_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_busy_after_start : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |=> !in_ready_o)
    else $error("block ready straight after a compute beat");

  a_mac_in_row : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_vld_q |-> (state_q == S_MAC || state_q == S_DRAIN))
    else $error("product accumulated outside the row pass");

  a_stall_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_BL_ADD && out_vld_q && !out_ready_i) |=> state_q == S_BL_ADD)
    else $error("result dropped while output register full");

  a_k_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MAC) |-> (int'(k_q) < INPUTS))
    else $error("row counter beyond last input");

endmodule

@@ verif/leaky_weighted_activation_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// leaky_weighted_activation_tb: self-checking bench for the activation block
// Fills the input vector and a set of weight rows, then runs directed and
// random weight writes, input writes and unit computes under several gain and
// leak settings. Both channels idle and stall at random. Every accepted result
// is compared with a bit-exact prediction of dot product, scaling and blend.
// ----------------------------------------------------------------------------
module leaky_weighted_activation_tb;
  import lwa_pkg::*;

  localparam int unsigned UNITS         = 64;
  localparam int unsigned INPUTS        = 64;
  localparam int unsigned FILLED_UNITS  = 12;
  localparam int unsigned SETTLE_CYCLES = 100;
  localparam int unsigned PHASE_ITEMS   = 220;
  localparam int unsigned PHASES        = 5;
  localparam int unsigned PRINT_CAP     = 40;
  localparam logic [ACTION_W-1:0] ACT_RESERVED = 2'd3;
  localparam logic [15:0] STRENGTH_DEFAULT = 16'd6554;
  localparam logic [15:0] LEAK_DEFAULT     = 16'd19661;

  typedef struct packed {
    bit [INDEX_W-1:0] unit;
    bit [ACT_W-1:0]   activity;
  } unit_result_t;

  // Keeps its own copy of the stores and registers and the results still owed
  class activity_scoreboard;
    bit [15:0]      weight_mem [UNITS*INPUTS];
    bit [15:0]      input_mem [INPUTS];
    bit [31:0]      activity_mem [UNITS];
    bit [15:0]      strength;
    bit [15:0]      leak_gain;
    unit_result_t   pending[$];
    int unsigned    errors;

    function new();
      foreach (activity_mem[i]) activity_mem[i] = '0;
      strength  = STRENGTH_DEFAULT;
      leak_gain = LEAK_DEFAULT;
      errors    = 0;
    endfunction

    function void set_config(cfg_reg_e idx, bit [15:0] value);
      if (idx == CFG_STRENGTH) strength = value;
      else leak_gain = value;
    endfunction

    // Row dot product, times strength, rounded half up to Q16.16, saturated
    function bit [31:0] fresh_activity(int unsigned unit);
      bit [63:0]   acc;
      bit [63:0]   scaled;
      int unsigned k;
      acc = '0;
      for (k = 0; k < INPUTS; k++)
        acc += 64'(weight_mem[unit*INPUTS + k]) * 64'(input_mem[k]);
      scaled = acc * 64'(strength);
      scaled = (scaled + (64'd1 << 21)) >> 22;
      if (scaled > 64'hFFFF_FFFF) return 32'hFFFF_FFFF;
      return scaled[31:0];
    endfunction

    function bit [31:0] blended_activity(bit [31:0] old_act, bit [31:0] fresh);
      bit [63:0] mix;
      mix = 64'(old_act) * (64'd65536 - 64'(leak_gain)) + 64'(fresh) * 64'(leak_gain)
            + 64'd32768;
      return mix[47:16];
    endfunction

    function void note_beat(logic [ACTION_W-1:0] act, logic [INDEX_W-1:0] unit,
                            logic [INDEX_W-1:0] pos, logic [SAMPLE_W-1:0] sample);
      unit_result_t res;
      case (act)
        ACT_WR_WEIGHT: weight_mem[unit*INPUTS + pos] = sample;
        ACT_WR_INPUT:  input_mem[pos] = sample;
        ACT_COMPUTE: begin
          res.unit     = unit;
          res.activity = blended_activity(activity_mem[unit], fresh_activity(32'(unit)));
          activity_mem[unit] = res.activity;
          pending.push_back(res);
        end
        default: ;  // reserved action: no effect
      endcase
    endfunction

    task report_mismatch(string what, bit [31:0] want, bit [31:0] got);
      if (errors < PRINT_CAP)
        $display("[%0t] %s: want %0h got %0h", $time, what, want, got);
      errors++;
    endtask

    task check_beat(logic [INDEX_W-1:0] unit, logic [ACT_W-1:0] activity);
      unit_result_t want;
      if (pending.size() == 0) begin
        report_mismatch("result beat with none owed", '0, activity);
      end else begin
        want = pending.pop_front();
        if (unit !== want.unit) report_mismatch("result_unit", 32'(want.unit), 32'(unit));
        if (activity !== want.activity)
          report_mismatch("unit_activity", want.activity, activity);
      end
    endtask
  endclass

  logic                  clk_i          = 1'b0;
  logic                  rst_ni         = 1'b0;
  logic                  cfg_we_i       = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i      = '0;
  logic [CFG_W-1:0]      cfg_wdata_i    = '0;
  logic                  in_valid_i     = 1'b0;
  logic                  in_ready_o;
  logic [ACTION_W-1:0]   action_i       = '0;
  logic [INDEX_W-1:0]    unit_index_i   = '0;
  logic [INDEX_W-1:0]    input_index_i  = '0;
  logic [SAMPLE_W-1:0]   sample_value_i = '0;
  logic                  out_valid_o;
  logic                  out_ready_i    = 1'b0;
  logic [INDEX_W-1:0]    result_unit_o;
  logic [ACT_W-1:0]      unit_activity_o;

  activity_scoreboard sb;
  bit                 in_calm;

  leaky_weighted_activation #(
    .UNITS  (UNITS),
    .INPUTS (INPUTS)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .action_i        (action_i),
    .unit_index_i    (unit_index_i),
    .input_index_i   (input_index_i),
    .sample_value_i  (sample_value_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .result_unit_o   (result_unit_o),
    .unit_activity_o (unit_activity_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 120);
  endfunction

  function automatic logic [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return 16'hFFF0 | SAMPLE_W'($urandom_range(0, 15));
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  function automatic logic [INDEX_W-1:0] pick_index();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return INDEX_W'($urandom_range(0, 63));
    endcase
  endfunction

  // Computes only touch rows that the fill wrote: the first few and the last
  function automatic logic [INDEX_W-1:0] pick_unit();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return INDEX_W'($urandom_range(0, FILLED_UNITS - 1));
    endcase
  endfunction

  // Beat bookkeeping: results are checked before the same edge's input is noted
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) sb.check_beat(result_unit_o, unit_activity_o);
      if (in_valid_i && in_ready_o)
        sb.note_beat(action_i, unit_index_i, input_index_i, sample_value_i);
    end
  end

  initial begin : out_side
    int unsigned run;
    int unsigned stall;
    @(posedge clk_i);
    forever begin
      out_ready_i <= 1'b1;
      run = ($urandom_range(0, 19) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 8);
      repeat (run) @(posedge clk_i);
      stall = pick_gap();
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
    end
  end

  // Valid stays high after the beat only when the next call follows in the same step
  task automatic send_beat(logic [ACTION_W-1:0] act, logic [INDEX_W-1:0] unit,
                           logic [INDEX_W-1:0] pos, logic [SAMPLE_W-1:0] sample);
    int unsigned gap;
    in_valid_i     <= 1'b1;
    action_i       <= act;
    unit_index_i   <= unit;
    input_index_i  <= pos;
    sample_value_i <= sample;
    do @(posedge clk_i); while (!in_ready_o);
    gap = in_calm ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    // let the last accepted beat reach the scoreboard first
    @(posedge clk_i);
    while (sb.pending.size() != 0) @(posedge clk_i);
    // a trailing write may still be in flight
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_config(logic [15:0] strength, logic [15:0] leak);
    drain_results();
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_STRENGTH;
    cfg_wdata_i <= strength;
    @(posedge clk_i);
    cfg_idx_i   <= CFG_LEAK;
    cfg_wdata_i <= leak;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.set_config(CFG_STRENGTH, strength);
    sb.set_config(CFG_LEAK, leak);
  endtask

  task automatic random_phase(int unsigned n_items);
    int unsigned counted;
    int unsigned r;
    counted = 0;
    while (counted < n_items) begin
      if (counted % 100 == 0) in_calm = ($urandom_range(0, 4) == 0);
      r = $urandom_range(0, 99);
      if (r < 5) begin
        send_beat(ACT_RESERVED, pick_index(), pick_index(), pick_sample());
      end else begin
        if (r < 40) send_beat(ACT_COMPUTE, pick_unit(), pick_index(), pick_sample());
        else if (r < 75) send_beat(ACT_WR_WEIGHT, pick_index(), pick_index(), pick_sample());
        else send_beat(ACT_WR_INPUT, pick_index(), pick_index(), pick_sample());
        counted++;
      end
      if ($urandom_range(0, 199) == 0) drain_results();
    end
  endtask

  initial begin : stimulus
    int unsigned u;
    int unsigned k;
    int unsigned p;
    sb      = new();
    in_calm = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Fill the inputs and the computed rows: inputs and row one at full scale
    for (k = 0; k < INPUTS; k++) send_beat(ACT_WR_INPUT, pick_index(), INDEX_W'(k), '1);
    for (u = 0; u < UNITS; u++) begin
      if (u < FILLED_UNITS || u == UNITS - 1) begin
        for (k = 0; k < INPUTS; k++)
          send_beat(ACT_WR_WEIGHT, INDEX_W'(u), INDEX_W'(k), (u == 1) ? '1 : pick_sample());
      end
    end

    // Directed: register defaults, first and repeated computes, reserved action
    send_beat(ACT_COMPUTE, 6'd0, '0, '0);
    send_beat(ACT_COMPUTE, 6'd63, '1, '1);
    send_beat(ACT_RESERVED, 6'd5, 6'd7, 16'h1234);
    send_beat(ACT_COMPUTE, 6'd0, '0, '0);
    // full gain and leak on the full-scale row
    set_config('1, '1);
    send_beat(ACT_COMPUTE, 6'd1, '0, '0);
    send_beat(ACT_COMPUTE, 6'd1, '0, '0);
    // no leak: activity holds
    set_config('0, '0);
    send_beat(ACT_COMPUTE, 6'd1, '0, '0);
    // zero gain, full leak: activity collapses
    set_config('0, '1);
    send_beat(ACT_COMPUTE, 6'd1, '0, '0);
    send_beat(ACT_COMPUTE, 6'd2, '0, '0);
    set_config('1, '0);
    send_beat(ACT_WR_WEIGHT, 6'd63, 6'd63, '1);
    send_beat(ACT_WR_WEIGHT, 6'd0, 6'd0, '0);
    send_beat(ACT_WR_WEIGHT, 6'd63, 6'd0, 16'h8000);
    send_beat(ACT_WR_INPUT, 6'd0, 6'd0, '0);
    send_beat(ACT_WR_INPUT, 6'd63, 6'd63, 16'h7FFF);
    send_beat(ACT_COMPUTE, 6'd63, '0, '0);
    send_beat(ACT_COMPUTE, 6'd0, '0, '0);
    set_config(16'h0100, 16'h8000);
    send_beat(ACT_COMPUTE, 6'd63, '0, '0);

    for (p = 0; p < PHASES; p++) begin
      case (p)
        0: set_config(STRENGTH_DEFAULT, LEAK_DEFAULT);
        1: set_config(16'($urandom), 16'($urandom));
        2: set_config('1, 16'($urandom));
        3: set_config(16'($urandom_range(0, 1023)), '1);
        default: set_config(16'($urandom), 16'($urandom_range(0, 4095)));
      endcase
      random_phase(PHASE_ITEMS);
    end

    drain_results();
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin : watchdog
    #(100_000_000);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/lwa_pkg.sv
rtl/leaky_weighted_activation.sv
verif/leaky_weighted_activation_tb.sv
